// ===== rtl/pgtg_pkg.sv =====
`default_nettype none
package pgtg_pkg;

   localparam int COORD_BITS    = 16;
   localparam int HEADING_BITS  = 15;
   localparam int CORDIC_STAGES = 16;
   localparam int GUARD_BITS    = 4;
   // CORDIC datapath widths: x/y hold the scaled difference plus the CORDIC gain.
   localparam int XW            = COORD_BITS + GUARD_BITS + 4;
   // Angle accumulator in units of 2^-16 rad.
   localparam int ZW            = 20;
   localparam int ATAN_LEN      = 24;

   localparam logic signed [ZW-1:0] HALF_PI_A16 = ZW'(102944);

   typedef struct packed {
      logic                         zero;
      logic signed [XW-1:0]         x;
      logic signed [XW-1:0]         y;
      logic signed [ZW-1:0]         z;
      logic signed [HEADING_BITS-1:0] hd;
   } cordic_type;

   // Arctangent of 2^-i, rounded to nearest in units of 2^-16 rad.
   function automatic logic signed [ZW-1:0] atan_entry(input int i);
      logic signed [ZW-1:0] r;
      unique case (i)
         0:  r = ZW'(51472);
         1:  r = ZW'(30386);
         2:  r = ZW'(16055);
         3:  r = ZW'(8150);
         4:  r = ZW'(4091);
         5:  r = ZW'(2047);
         6:  r = ZW'(1024);
         7:  r = ZW'(512);
         8:  r = ZW'(256);
         9:  r = ZW'(128);
         10: r = ZW'(64);
         11: r = ZW'(32);
         12: r = ZW'(16);
         13: r = ZW'(8);
         14: r = ZW'(4);
         15: r = ZW'(2);
         16: r = ZW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/pgtg_cordic.sv =====
`default_nettype none
module pgtg_cordic (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                en,
   input  wire logic                in_vld,
   input  wire pgtg_pkg::cordic_type in_data,
   output logic                     out_vld,
   output pgtg_pkg::cordic_type     out_data
);
   import pgtg_pkg::*;

   // One vectoring micro-rotation per register stage.
   logic       vld_ff  [0:CORDIC_STAGES];
   cordic_type data_ff [0:CORDIC_STAGES];
   cordic_type data_in [1:CORDIC_STAGES];

   assign vld_ff[0]  = in_vld;
   assign data_ff[0] = in_data;

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stage
      always_comb begin
         logic signed [XW-1:0] xs;
         logic signed [XW-1:0] ys;
         xs = data_ff[i].x >>> i;
         ys = data_ff[i].y >>> i;
         data_in[i+1] = data_ff[i];
         if (data_ff[i].y >= 0) begin
            data_in[i+1].x = data_ff[i].x + ys;
            data_in[i+1].y = data_ff[i].y - xs;
            data_in[i+1].z = data_ff[i].z + atan_entry(i);
         end else begin
            data_in[i+1].x = data_ff[i].x - ys;
            data_in[i+1].y = data_ff[i].y + xs;
            data_in[i+1].z = data_ff[i].z - atan_entry(i);
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (en) begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            data_ff[i+1] <= data_in[i+1];
         end
      end
   end

   assign out_vld  = vld_ff[CORDIC_STAGES];
   assign out_data = data_ff[CORDIC_STAGES];

endmodule
`default_nettype wire

// ===== rtl/polar_go_to_goal_wheel_speeds.sv =====
`default_nettype none
// Pipeline: a request transaction passes one prerotation stage, 16 CORDIC stages
// and seven arithmetic stages before its result is presented.
// Throughput: one transaction per cycle; the whole pipeline advances together and
// holds while the result register is full and rsp_tready is low.
// Reset: synchronous active-high reset empties the pipeline and loads the default gains.
module polar_go_to_goal_wheel_speeds (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // robot_x[15:0], robot_z[31:16], robot_heading[46:32], goal_x[62:47],
   // goal_z[78:63], zero pad [79]
   input  wire logic [79:0] req_tdata,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // left wheel command[15:0], right wheel command[31:16]
   output logic [31:0]      rsp_tdata,
   // at_goal[0]
   output logic             rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [4:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import pgtg_pkg::*;

   localparam logic [2:0] REG_GAIN_DIST  = 3'd0;
   localparam logic [2:0] REG_GAIN_BEAR  = 3'd1;
   localparam logic [2:0] REG_GAIN_FINAL = 3'd2;
   localparam logic [2:0] REG_HALF_BASE  = 3'd3;
   localparam logic [2:0] REG_MAX_SPEED  = 3'd4;
   localparam logic [2:0] REG_STOP_RAD   = 3'd5;

   localparam logic signed [16:0] INV_K_Q16  = 17'sd39797;
   localparam logic signed [17:0] PI_Q12     = 18'sd12868;
   localparam logic signed [17:0] TWO_PI_Q12 = 18'sd25736;

   // ---------------------------------------------------------------------
   // Configuration registers. Writes land on the access phase of an APB
   // transaction; addresses outside the register list are ignored.
   // ---------------------------------------------------------------------
   logic [14:0]        gain_dist_ff;
   logic [14:0]        gain_bear_ff;
   logic signed [15:0] gain_final_ff;
   logic [11:0]        half_base_ff;
   logic [14:0]        max_speed_ff;
   logic [14:0]        stop_rad_ff;
   logic [2:0]         csr_index;
   logic               csr_write;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_dist_ff  <= 15'd20480;
         gain_bear_ff  <= 15'd20480;
         gain_final_ff <= -16'sd328;
         half_base_ff  <= 12'd143;
         max_speed_ff  <= 15'd25723;
         stop_rad_ff   <= 15'd123;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_GAIN_DIST:  gain_dist_ff  <= csr_pwdata[14:0];
            REG_GAIN_BEAR:  gain_bear_ff  <= csr_pwdata[14:0];
            REG_GAIN_FINAL: gain_final_ff <= $signed(csr_pwdata[15:0]);
            REG_HALF_BASE:  half_base_ff  <= csr_pwdata[11:0];
            REG_MAX_SPEED:  max_speed_ff  <= csr_pwdata[14:0];
            REG_STOP_RAD:   stop_rad_ff   <= csr_pwdata[14:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_GAIN_DIST:  csr_prdata = 32'(gain_dist_ff);
         REG_GAIN_BEAR:  csr_prdata = 32'(gain_bear_ff);
         REG_GAIN_FINAL: csr_prdata = 32'($unsigned(gain_final_ff));
         REG_HALF_BASE:  csr_prdata = 32'(half_base_ff);
         REG_MAX_SPEED:  csr_prdata = 32'(max_speed_ff);
         REG_STOP_RAD:   csr_prdata = 32'(stop_rad_ff);
         default:        csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Pipeline control. Every stage moves when the result register is empty
   // or being drained, so an item can enter each cycle and nothing is lost
   // or repeated on a stall.
   // ---------------------------------------------------------------------
   logic en;
   logic vld_p0_ff, vld_m1_ff, vld_m2_ff, vld_m3_ff, vld_m4_ff, vld_m5_ff, vld_m6_ff;
   logic vld_out_ff;
   logic cordic_vld;

   assign en         = !vld_out_ff || rsp_tready;
   assign req_tready = en;

   // Stage P0: differences scaled by 2^4, then a quarter turn for negative dz
   // so the CORDIC only has to cover the right half plane.
   logic signed [COORD_BITS-1:0]   rx, rz, gx, gz;
   logic signed [HEADING_BITS-1:0] hd;
   logic signed [XW-1:0]           dx, dz;
   cordic_type                     pre_in, pre_ff, cordic_out;

   assign rx = $signed(req_tdata[15:0]);
   assign rz = $signed(req_tdata[31:16]);
   assign hd = $signed(req_tdata[46:32]);
   assign gx = $signed(req_tdata[62:47]);
   assign gz = $signed(req_tdata[78:63]);

   always_comb begin
      dx = (XW'(gx) - XW'(rx)) <<< GUARD_BITS;
      dz = (XW'(gz) - XW'(rz)) <<< GUARD_BITS;
      pre_in.hd   = hd;
      pre_in.zero = (dx == 0) && (dz == 0);
      if (dz < 0) begin
         if (dx >= 0) begin
            pre_in.x = dx;
            pre_in.y = -dz;
            pre_in.z = HALF_PI_A16;
         end else begin
            pre_in.x = -dx;
            pre_in.y = dz;
            pre_in.z = -HALF_PI_A16;
         end
      end else begin
         pre_in.x = dz;
         pre_in.y = dx;
         pre_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pre_ff <= pre_in;
      end
   end

   pgtg_cordic u_cordic (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_vld   (vld_p0_ff),
      .in_data  (pre_ff),
      .out_vld  (cordic_vld),
      .out_data (cordic_out)
   );

   // Stage M1: magnitude times 1/K, bearing rounded to Q3.12. A goal on the
   // robot itself reads as zero bearing.
   logic signed [XW+16:0]          rho_prod_in, rho_prod_ff;
   logic signed [15:0]             bear_in, bear_ff;
   logic signed [ZW-1:0]           bear_sum;
   logic signed [HEADING_BITS-1:0] hd_m1_ff, hd_m2_ff;

   always_comb begin
      rho_prod_in = (XW+17)'(cordic_out.x) * (XW+17)'(INV_K_Q16);
      bear_sum    = cordic_out.z + ZW'(8);
      bear_in     = cordic_out.zero ? '0 : bear_sum[19:4];
   end

   // Stage M2: rho rounded to Q7.12, bearing error wrapped once.
   logic signed [XW+16:0] rho_round;
   logic signed [19:0]    rho_in, rho_ff;
   logic signed [16:0]    alpha_raw;
   logic signed [17:0]    alpha_in, alpha_m2_ff, alpha_m3_ff;

   always_comb begin
      rho_round = rho_prod_ff + (XW+17)'(1 <<< 19);
      rho_in    = rho_round[39:20];
      alpha_raw = 17'(bear_ff) - 17'(hd_m1_ff);
      if (18'(alpha_raw) > PI_Q12) begin
         alpha_in = 18'(alpha_raw) - TWO_PI_Q12;
      end else if (18'(alpha_raw) < -PI_Q12) begin
         alpha_in = 18'(alpha_raw) + TWO_PI_Q12;
      end else begin
         alpha_in = 18'(alpha_raw);
      end
   end

   // Stage M3: beta, forward-speed product, stop-radius test.
   logic signed [18:0] beta_in, beta_ff;
   logic signed [35:0] v_prod_in, v_prod_ff;
   logic               at_goal_in;
   logic               at_goal_m3_ff, at_goal_m4_ff, at_goal_m5_ff, at_goal_m6_ff;

   always_comb begin
      beta_in    = -19'(hd_m2_ff) - 19'(alpha_m2_ff);
      v_prod_in  = 36'($signed({1'b0, gain_dist_ff})) * 36'(rho_ff);
      at_goal_in = rho_ff < 20'($signed({1'b0, stop_rad_ff}));
   end

   // Stage M4: both turn-rate products and the rounded forward speed.
   logic signed [33:0] pa_in, pa_ff;
   logic signed [34:0] pb_in, pb_ff;
   logic signed [35:0] v_round;
   logic signed [23:0] v_in, v_m4_ff, v_m5_ff, v_m6_ff;

   always_comb begin
      pa_in   = 34'($signed({1'b0, gain_bear_ff})) * 34'(alpha_m3_ff);
      pb_in   = 35'(gain_final_ff) * 35'(beta_ff);
      v_round = v_prod_ff + 36'sd2048;
      v_in    = v_round[35:12];
   end

   // Stage M5: turn rate w rounded to Q.12.
   logic signed [36:0] w_sum;
   logic signed [24:0] w_in, w_ff;

   always_comb begin
      w_sum = 37'(pa_ff) + 37'(pb_ff) + 37'sd2048;
      w_in  = w_sum[36:12];
   end

   // Stage M6: half wheel base times w.
   logic signed [37:0] hw_prod_in, hw_prod_ff;

   assign hw_prod_in = 38'($signed({1'b0, half_base_ff})) * 38'(w_ff);

   // Stage M7: wheel sums, independent saturation of each wheel, stop override.
   logic signed [37:0] hw_round;
   logic signed [26:0] hw, left, right, lim;
   logic signed [15:0] left_in, right_in, left_ff, right_ff;
   logic               at_goal_ff;

   always_comb begin
      hw_round = hw_prod_ff + 38'sd2048;
      hw       = 27'($signed(hw_round[37:12]));
      lim      = 27'($signed({1'b0, max_speed_ff}));
      left     = 27'(v_m6_ff) + hw;
      right    = 27'(v_m6_ff) - hw;
      if (left > lim) begin
         left = lim;
      end else if (left < -lim) begin
         left = -lim;
      end
      if (right > lim) begin
         right = lim;
      end else if (right < -lim) begin
         right = -lim;
      end
      left_in  = at_goal_m6_ff ? '0 : left[15:0];
      right_in = at_goal_m6_ff ? '0 : right[15:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rho_prod_ff   <= rho_prod_in;
         bear_ff       <= bear_in;
         hd_m1_ff      <= cordic_out.hd;
         rho_ff        <= rho_in;
         alpha_m2_ff   <= alpha_in;
         hd_m2_ff      <= hd_m1_ff;
         beta_ff       <= beta_in;
         alpha_m3_ff   <= alpha_m2_ff;
         v_prod_ff     <= v_prod_in;
         at_goal_m3_ff <= at_goal_in;
         pa_ff         <= pa_in;
         pb_ff         <= pb_in;
         v_m4_ff       <= v_in;
         at_goal_m4_ff <= at_goal_m3_ff;
         w_ff          <= w_in;
         v_m5_ff       <= v_m4_ff;
         at_goal_m5_ff <= at_goal_m4_ff;
         hw_prod_ff    <= hw_prod_in;
         v_m6_ff       <= v_m5_ff;
         at_goal_m6_ff <= at_goal_m5_ff;
         left_ff       <= left_in;
         right_ff      <= right_in;
         at_goal_ff    <= at_goal_m6_ff;
      end
   end

   // Valid bits travel alongside the data and are the only reset state in the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_p0_ff  <= 1'b0;
         vld_m1_ff  <= 1'b0;
         vld_m2_ff  <= 1'b0;
         vld_m3_ff  <= 1'b0;
         vld_m4_ff  <= 1'b0;
         vld_m5_ff  <= 1'b0;
         vld_m6_ff  <= 1'b0;
         vld_out_ff <= 1'b0;
      end else if (en) begin
         vld_p0_ff  <= req_tvalid;
         vld_m1_ff  <= cordic_vld;
         vld_m2_ff  <= vld_m1_ff;
         vld_m3_ff  <= vld_m2_ff;
         vld_m4_ff  <= vld_m3_ff;
         vld_m5_ff  <= vld_m4_ff;
         vld_m6_ff  <= vld_m5_ff;
         vld_out_ff <= vld_m6_ff;
      end
   end

   assign rsp_tvalid = vld_out_ff;
   assign rsp_tdata  = {right_ff, left_ff};
   assign rsp_tuser  = at_goal_ff;

   // The stop condition forces both wheel commands to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == 32'd0)
      else $error("at_goal result carries nonzero wheel speeds");

   // An empty result register never back-pressures the request side.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("request stalled with an empty result register");

   // Each wheel command stays within the saturation limit.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $signed(left_ff) <= $signed({1'b0, max_speed_ff})
                  && $signed(left_ff) >= -$signed({1'b0, max_speed_ff})
                  && $signed(right_ff) <= $signed({1'b0, max_speed_ff})
                  && $signed(right_ff) >= -$signed({1'b0, max_speed_ff}))
      else $error("wheel speed outside saturation limit");

   // A stall freezes the whole pipeline, including the stage feeding the output.
   assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_m6_ff) && $stable(left_ff))
      else $error("pipeline moved during a stall");

endmodule
`default_nettype wire
